/* sv/lfd_pkg.sv */
// Shared types and constants for the length-field byte deframer.
// No dependencies; imported by every module of the block.
package lfd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0]  PrefixTrigger  = 8'hFD;
  localparam logic [7:0]  PrefixByte     = 8'hFF;
  localparam logic [6:0]  HeaderBytes    = 7'd7;
  localparam logic [6:0]  MinFrameBytes  = 7'd4;
  localparam logic [6:0]  LengthBytePos  = 7'd2;
  localparam logic [5:0]  FixedCmdLength = 6'd11;
  localparam logic [15:0] TimeoutReset   = 16'd10;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_END     = 2'd1,
    EV_DISCARD = 2'd2,
    EV_NONE    = 2'd3
  } lfd_event_t;

  // One queue entry per accepted input; prefix asks the back end for an
  // extra 0xFF result ahead of the stored one.
  typedef struct packed {
    logic       prefix;
    logic [7:0] out_byte;
    logic [6:0] position;
    lfd_event_t event_res;
    logic [6:0] frame_length;
  } lfd_entry_t;

endpackage

/* sv/length_field_byte_deframer_top.sv */
// Top level of the length-field byte deframer.
// Instantiates lfd_front, lfd_fifo and lfd_back; uses lfd_pkg.
//
// Usage:
//   Input stream: s_axis_tuser = action (0 received byte, 1 timer tick),
//   s_axis_tdata = received byte. Each transaction gives one result, or
//   two when the first byte of a frame is 0xFD (a 0xFF result goes first).
//   Output stream: tdata = out_byte, position, frame_length (low bit up),
//   tuser = event (byte, frame end, timeout discard, nothing), tlast marks
//   the last result of one input transaction.
//   cfg_we/cfg_wdata write timeout_ticks (reset 10); write only when idle.
// Path: an accepted input is stored in the queue, then loaded into the back end's output register.
// Throughput: one input per cycle while the queue has room; a prefixed input
//   gives two results, sent in turn by the single output register of the back end.
// Reset (rst, synchronous): clears frame state, deadline and the 4-entry
//   queue; timeout returns to 10 ticks.
// When the receiver stalls, the back end holds its result and the queue
//   absorbs up to four inputs before s_axis_tready drops.
module length_field_byte_deframer_top import lfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] out_byte, [14:8] position, [21:15] frame_length
  output logic [1:0]  m_axis_tuser,  // [1:0] event_res
  output logic        m_axis_tlast
);

  lfd_entry_t push_entry, head;
  logic       push, pop, full, empty;
  logic [7:0] out_byte;
  logic [6:0] out_position, out_frame_length;
  lfd_event_t out_event;

  lfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_action  (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .queue_full (full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  lfd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  lfd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_byte         (out_byte),
    .out_position     (out_position),
    .out_event        (out_event),
    .out_frame_length (out_frame_length),
    .out_last         (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_frame_length, out_position, out_byte};
  assign m_axis_tuser = out_event;

endmodule

/* sv/lfd_front.sv */
// Front end: accepts bytes and ticks, tracks frame state and deadline,
// and pushes one classified entry per transaction. Uses lfd_pkg.
module lfd_front import lfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_action,
  input  logic [7:0]  in_byte,
  input  logic        queue_full,
  output logic        in_ready,
  output logic        push,
  output lfd_entry_t  push_entry
);

  logic [15:0] timeout_ticks;
  logic [6:0]  byte_position, byte_position_next;
  logic [5:0]  payload_length, payload_length_next;
  logic [15:0] deadline_count, deadline_count_next;
  logic        deadline_running, deadline_running_next;

  logic [6:0] pos;
  logic [6:0] len;
  logic [5:0] plen;
  logic       complete;

  function automatic logic [5:0] decode_length(input logic [7:0] b);
    logic [5:0] cmd;
    cmd = b[5:0];
    if (b[6]) return cmd;
    if (cmd == 6'd2 || cmd == 6'd3 || cmd == 6'd4) return FixedCmdLength;
    return 6'd0;
  endfunction

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    byte_position_next    = byte_position;
    payload_length_next   = payload_length;
    deadline_count_next   = deadline_count;
    deadline_running_next = deadline_running;
    push_entry            = '0;
    push_entry.event_res  = EV_NONE;
    pos                   = byte_position;
    plen                  = payload_length;
    len                   = '0;
    complete              = 1'b0;
    if (in_action) begin
      // timer tick
      if (deadline_running && deadline_count <= 16'd1) begin
        push_entry.event_res    = EV_DISCARD;
        push_entry.frame_length = byte_position;
        byte_position_next      = '0;
        payload_length_next     = '0;
        deadline_count_next     = '0;
        deadline_running_next   = 1'b0;
      end else begin
        if (deadline_running) deadline_count_next = deadline_count - 16'd1;
      end
    end else begin
      if (byte_position == 7'd0) begin
        deadline_running_next = 1'b1;
        deadline_count_next   = timeout_ticks;
        if (in_byte == PrefixTrigger) begin
          push_entry.prefix = 1'b1;
          pos               = 7'd1;
        end
      end
      len = pos + 7'd1;
      if (pos == LengthBytePos) plen = decode_length(in_byte);
      payload_length_next = plen;
      complete = (len >= MinFrameBytes) && (len >= HeaderBytes + {1'b0, plen});
      push_entry.out_byte = in_byte;
      push_entry.position = pos;
      if (complete) begin
        push_entry.event_res    = EV_END;
        push_entry.frame_length = len;
        byte_position_next      = '0;
        payload_length_next     = '0;
        deadline_count_next     = '0;
        deadline_running_next   = 1'b0;
      end else begin
        push_entry.event_res = EV_BYTE;
        byte_position_next   = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks    <= TimeoutReset;
      byte_position    <= '0;
      payload_length   <= '0;
      deadline_count   <= '0;
      deadline_running <= 1'b0;
    end else begin
      if (cfg_we) timeout_ticks <= cfg_wdata;
      if (push) begin
        byte_position    <= byte_position_next;
        payload_length   <= payload_length_next;
        deadline_count   <= deadline_count_next;
        deadline_running <= deadline_running_next;
      end
    end
  end

endmodule

/* sv/lfd_fifo.sv */
// Short entry queue between front and back ends.
// Uses lfd_pkg for the entry type and depth.
module lfd_fifo import lfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lfd_entry_t push_entry,
  input  logic       pop,
  output lfd_entry_t head,
  output logic       full,
  output logic       empty
);

  lfd_entry_t           slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full  = (count == QueueCntW'(QueueDepth));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* sv/lfd_back.sv */
// Back end: expands queue entries into result transactions, inserting
// the 0xFF prefix result where flagged, into an output register. Uses lfd_pkg.
module lfd_back import lfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lfd_entry_t  head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [6:0]  out_position,
  output lfd_event_t  out_event,
  output logic [6:0]  out_frame_length,
  output logic        out_last
);

  logic prefix_done;
  logic load;
  logic emit_prefix;

  assign load        = !empty && (!out_valid || out_ready);
  assign emit_prefix = head.prefix && !prefix_done;
  assign pop         = load && !emit_prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      prefix_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        prefix_done <= emit_prefix;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_prefix) begin
        out_byte         <= PrefixByte;
        out_position     <= '0;
        out_event        <= EV_BYTE;
        out_frame_length <= '0;
        out_last         <= 1'b0;
      end else begin
        out_byte         <= head.out_byte;
        out_position     <= head.position;
        out_event        <= head.event_res;
        out_frame_length <= head.frame_length;
        out_last         <= 1'b1;
      end
    end
  end

endmodule

/* sim/lfd_frame_check.sv */
// Result checking for the length-field byte deframer testbench.
// Watches both stream channels and the config port, predicts each result.
// Depends on lfd_pkg for the event codes and framing constants.
`timescale 1ns / 1ps

module lfd_frame_check import lfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // [7:0] out_byte, [14:8] position, [21:15] frame_length
  input  logic [1:0]  m_axis_tuser,  // [1:0] event_res
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          results_due,
  output int          frames_closed,
  output int          frames_dropped,
  output int          prefixes_added
);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] position;
    lfd_event_t ev;
    logic [6:0] frame_length;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];

  // predicted frame state
  logic [15:0] timeout_cfg;
  logic [6:0]  hold_count;
  logic [5:0]  body_len;
  logic [15:0] ticks_left;
  logic        deadline_armed;

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_result(input logic [7:0] b, input logic [6:0] pos,
                             input lfd_event_t ev, input logic [6:0] flen,
                             input logic last);
    frame_result_t r;
    r.out_byte     = b;
    r.position     = pos;
    r.ev           = ev;
    r.frame_length = flen;
    r.last         = last;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic drop_frame();
    hold_count     = '0;
    body_len       = '0;
    ticks_left     = '0;
    deadline_armed = 1'b0;
  endtask

  task automatic predict_input(input logic tick, input logic [7:0] b);
    int unsigned held;
    if (tick) begin
      if (deadline_armed && ticks_left <= 16'd1) begin
        push_result(8'h00, 7'd0, EV_DISCARD, hold_count, 1'b1);
        frames_dropped++;
        drop_frame();
      end else begin
        if (deadline_armed) ticks_left = ticks_left - 16'd1;
        push_result(8'h00, 7'd0, EV_NONE, 7'd0, 1'b1);
      end
    end else begin
      if (hold_count == 7'd0) begin
        deadline_armed = 1'b1;
        ticks_left     = timeout_cfg;
        if (b == PrefixTrigger) begin
          push_result(PrefixByte, 7'd0, EV_BYTE, 7'd0, 1'b0);
          hold_count = 7'd1;
          prefixes_added++;
        end
      end
      // length byte: explicit length with 0x40, else fixed length for commands 2..4
      if (hold_count == LengthBytePos) begin
        if (b[6])
          body_len = b[5:0];
        else if (b[5:0] >= 6'd2 && b[5:0] <= 6'd4)
          body_len = FixedCmdLength;
        else
          body_len = 6'd0;
      end
      held = hold_count + 1;
      if (held >= MinFrameBytes && held >= HeaderBytes + body_len) begin
        push_result(b, hold_count, EV_END, 7'(held), 1'b1);
        frames_closed++;
        drop_frame();
      end else begin
        push_result(b, hold_count, EV_BYTE, 7'd0, 1'b1);
        hold_count = 7'(held);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      timeout_cfg = TimeoutReset;
      drop_frame();
      expected_results.delete();
      mismatches     = 0;
      frames_closed  = 0;
      frames_dropped = 0;
      prefixes_added = 0;
    end else begin
      if (cfg_we) timeout_cfg = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata %h tuser %0d tlast %b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (m_axis_tdata[7:0] !== want.out_byte || m_axis_tdata[14:8] !== want.position ||
              m_axis_tdata[21:15] !== want.frame_length || m_axis_tdata[23:22] !== 2'b00 ||
              m_axis_tuser !== want.ev || m_axis_tlast !== want.last)
            report_mismatch({
              $sformatf("got byte %h pos %0d len %0d pad %b ev %0d last %b, ",
                        m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tdata[21:15],
                        m_axis_tdata[23:22], m_axis_tuser, m_axis_tlast),
              $sformatf("want byte %h pos %0d len %0d ev %0d last %b",
                        want.out_byte, want.position, want.frame_length,
                        want.ev, want.last)});
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_input(s_axis_tuser, s_axis_tdata);
    end
    results_due = expected_results.size();
  end

endmodule

/* sim/tb_length_field_byte_deframer_top.sv */
// Testbench top for length_field_byte_deframer_top: clock, reset, stimulus and verdict.
// Uses lfd_frame_check for prediction and comparison; depends on lfd_pkg.
`timescale 1ns / 1ps

module tb_length_field_byte_deframer_top import lfd_pkg::*;;

  localparam int IdleLimit     = 5000;
  localparam int ItemsPerPhase = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic        s_axis_tuser = 1'b0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [7:0] out_byte, [14:8] position, [21:15] frame_length
  logic [1:0]  m_axis_tuser;  // [1:0] event_res
  logic        m_axis_tlast;

  int mismatches, results_due, frames_closed, frames_dropped, prefixes_added;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int inputs_sent = 0;
  int idle_cycles = 0;
  logic [15:0] cur_timeout = TimeoutReset;

  length_field_byte_deframer_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lfd_frame_check frame_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatches     (mismatches),
    .results_due    (results_due),
    .frames_closed  (frames_closed),
    .frames_dropped (frames_dropped),
    .prefixes_added (prefixes_added)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // stall watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the transaction happens.
  // tready is read at the falling edge, where it is settled.
  task automatic send_item(input logic tick, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tick;
    s_axis_tdata  <= b;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    inputs_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_timeout = v;
  endtask

  // Mostly whole frames with random content; junk and truncated frames only
  // where the timeout is short enough to flush them back into alignment.
  task automatic random_traffic(input int n);
    int stop_at, kind, body, nbytes, len_idx, flush, k;
    logic [7:0] first, len_byte, b;
    logic allow_junk;
    stop_at = inputs_sent + n;
    allow_junk = (cur_timeout <= 16'd64);
    while (inputs_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 72 || !allow_junk) begin
        first = ($urandom_range(2) == 0) ? PrefixTrigger : 8'($urandom);
        case ($urandom_range(2))
          0: len_byte = {1'($urandom), 1'b1,
                         ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(6))};
          1: len_byte = {1'($urandom), 1'b0, 6'($urandom_range(4, 2))};
          default: len_byte = 8'($urandom);
        endcase
        if (len_byte[6])
          body = len_byte[5:0];
        else if (len_byte[5:0] >= 6'd2 && len_byte[5:0] <= 6'd4)
          body = 11;
        else
          body = 0;
        // with the prefix the length byte is the second one received
        len_idx = (first == PrefixTrigger) ? 1 : 2;
        nbytes  = 7 + body - ((first == PrefixTrigger) ? 1 : 0);
        for (k = 0; k < nbytes; k++) begin
          if ($urandom_range(99) < 3) send_item(1'b1, 8'($urandom));
          if (k == 0)
            b = first;
          else if (k == len_idx)
            b = len_byte;
          else
            b = ($urandom_range(15) == 0) ? PrefixTrigger : 8'($urandom);
          send_item(1'b0, b);
        end
        if ($urandom_range(9) == 0) send_item(1'b1, 8'($urandom));
      end else begin
        if (kind < 88) begin
          // truncated frame
          send_item(1'b0, ($urandom_range(1) == 0) ? PrefixTrigger : 8'($urandom));
          for (k = $urandom_range(4); k > 0; k--) send_item(1'b0, 8'($urandom));
        end else begin
          for (k = $urandom_range(6, 1); k > 0; k--) send_item(1'($urandom), 8'($urandom));
        end
        flush = (cur_timeout == 16'd0) ? 1 : int'(cur_timeout);
        for (k = 0; k < flush; k++) send_item(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: prefixed frame, idle tick, plain frame with an unknown command
    send_item(1'b0, 8'hFD);
    send_item(1'b0, 8'h40);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h02);
    send_item(1'b0, 8'h03);
    send_item(1'b0, 8'h04);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h05);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    // zero timeout discards on the first tick, prefix-only frame has length 2
    write_timeout(16'd0);
    send_item(1'b0, 8'hFD);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    write_timeout(16'd2);
    send_item(1'b0, 8'h12);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);

    write_timeout(16'd3);
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_traffic(ItemsPerPhase);

    write_timeout(16'd1);
    send_idle_pct = 84; recv_stall_pct = 0;
    random_traffic(ItemsPerPhase);

    write_timeout(16'hFFFF);
    send_idle_pct = 0;  recv_stall_pct = 84;
    random_traffic(ItemsPerPhase);

    write_timeout(16'd0);
    send_idle_pct = 23; recv_stall_pct = 23;
    random_traffic(ItemsPerPhase);

    write_timeout(16'd64);
    send_idle_pct = 0;  recv_stall_pct = 0;
    random_traffic(ItemsPerPhase);

    wait_drained();
    repeat (5) @(posedge clk);
    $display("Sent %0d inputs over five timeout settings and idling mixes;", inputs_sent);
    $display("saw %0d complete frames, %0d timeout discards, %0d prefixed frames.",
             frames_closed, frames_dropped, prefixes_added);
    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* length_field_byte_deframer_top.f */
sv/lfd_pkg.sv
sv/lfd_front.sv
sv/lfd_fifo.sv
sv/lfd_back.sv
sv/length_field_byte_deframer_top.sv
sim/lfd_frame_check.sv
sim/tb_length_field_byte_deframer_top.sv
